// File: rtl/qszp_pkg.sv
// Shared types and constants for the quantization scale / zero-point calibrator.
// Used by qszp_unit and quant_scale_zero_point_calibrator.
`default_nettype none
package qszp_pkg;
	localparam int MAX_SAMPLES_DEF = 65536;
	localparam int SAMPLE_W = 24;
	localparam int SUM_W = 40;
	localparam int SQ_W = 64;
	localparam int ACC_W = 80;   // product / dividend width of the shared unit
	localparam int OPB_W = 64;   // multiplicand / divisor width
	localparam int REM_W = 65;
	localparam int CNT_IT_W = 7;
	localparam int MUL_STEPS = 40;
	localparam int DIV_STEPS = 80;
	localparam int SQRT_STEPS = 32;
	localparam int SCALE_W = 24;
	localparam int ZP_W = 25;
	localparam int ZP_MAX = 16777215;
	localparam int ZP_MIN = -16777216;
	localparam int ZP_BIAS = 127;
	// ceil(2^44 / 255): (x * RECIP_255) >> 44 equals floor(x / 255) for x below 2^36
	localparam logic [63:0] RECIP_255 = 64'd68988964881;
	localparam int RECIP_SHIFT = 44;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_SINGLE = 2'd2,
		ST_ZERO   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_MUL  = 2'd0,
		OP_DIV  = 2'd1,
		OP_SQRT = 2'd2
	} op_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} unit_ctl_t;
endpackage
`default_nettype wire

// File: rtl/qszp_unit.sv
// Iterative shared arithmetic unit: shift-add multiply, restoring divide, integer root.
// Depends on qszp_pkg.
`default_nettype none
module qszp_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire qszp_pkg::unit_ctl_t          ctl,
	input  wire logic [qszp_pkg::ACC_W-1:0]   opa,
	input  wire logic [qszp_pkg::OPB_W-1:0]   opb,
	output logic                              done,
	output logic [qszp_pkg::ACC_W-1:0]        res
);
	qszp_pkg::op_t                   op_q;
	logic                            busy_q;
	logic                            done_q;
	logic [qszp_pkg::CNT_IT_W-1:0]   cnt_q;
	logic [qszp_pkg::ACC_W-1:0]      acc_q;
	logic [qszp_pkg::ACC_W-1:0]      sh_q;
	logic [qszp_pkg::OPB_W-1:0]      b_q;
	logic [qszp_pkg::REM_W-1:0]      rem_q;

	logic [qszp_pkg::ACC_W-1:0] mul_nx;
	logic [qszp_pkg::REM_W-1:0] drem;
	logic [34:0]                srem, strial;
	logic [qszp_pkg::CNT_IT_W-1:0] last_it;
	logic                       last_step;

	always_comb begin
		mul_nx = {acc_q[qszp_pkg::ACC_W-2:0], 1'b0}
			+ (sh_q[qszp_pkg::ACC_W-1] ? qszp_pkg::ACC_W'(b_q) : '0);
		drem = {rem_q[qszp_pkg::REM_W-2:0], sh_q[qszp_pkg::ACC_W-1]};
		srem = {rem_q[32:0], sh_q[qszp_pkg::ACC_W-1 -: 2]};
		strial = {1'b0, acc_q[31:0], 2'b01};
		case (op_q)
			qszp_pkg::OP_MUL:  last_it = qszp_pkg::CNT_IT_W'(qszp_pkg::MUL_STEPS - 1);
			qszp_pkg::OP_DIV:  last_it = qszp_pkg::CNT_IT_W'(qszp_pkg::DIV_STEPS - 1);
			default:           last_it = qszp_pkg::CNT_IT_W'(qszp_pkg::SQRT_STEPS - 1);
		endcase
	end

	// the final step is written at the edge that ends last_step; flag the result after it
	assign last_step = busy_q && (cnt_q == last_it);
	assign res = acc_q;
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= last_step && !ctl.start;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			op_q <= qszp_pkg::OP_MUL;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			cnt_q <= '0;
			op_q <= ctl.op;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (last_step) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			acc_q <= '0;
			rem_q <= '0;
			b_q <= opb;
			case (ctl.op)
				qszp_pkg::OP_MUL:  sh_q <= {opa[39:0], 40'b0};
				qszp_pkg::OP_SQRT: sh_q <= {opa[63:0], 16'b0};
				default:           sh_q <= opa;
			endcase
		end else if (busy_q) begin
			case (op_q)
				qszp_pkg::OP_MUL: begin
					acc_q <= mul_nx;
					sh_q <= sh_q << 1;
				end
				qszp_pkg::OP_DIV: begin
					sh_q <= sh_q << 1;
					if (drem >= qszp_pkg::REM_W'(b_q)) begin
						rem_q <= drem - qszp_pkg::REM_W'(b_q);
						acc_q <= {acc_q[qszp_pkg::ACC_W-2:0], 1'b1};
					end else begin
						rem_q <= drem;
						acc_q <= {acc_q[qszp_pkg::ACC_W-2:0], 1'b0};
					end
				end
				default: begin
					sh_q <= sh_q << 2;
					if (srem >= strial) begin
						rem_q <= qszp_pkg::REM_W'(srem - strial);
						acc_q <= {acc_q[qszp_pkg::ACC_W-2:0], 1'b1};
					end else begin
						rem_q <= qszp_pkg::REM_W'(srem);
						acc_q <= {acc_q[qszp_pkg::ACC_W-2:0], 1'b0};
					end
				end
			endcase
		end
	end
endmodule
`default_nettype wire

// File: rtl/quant_scale_zero_point_calibrator.sv
// Quantization scale / zero-point calibrator, top level.
// Depends on qszp_pkg and qszp_unit.
//
// Input channel (in_valid / in_stall) carries sample, has_sample and is_last.
// A transaction with has_sample set adds the sample to exact running sums
// (count, sum, sum of squares); samples past MAX_SAMPLES are dropped. While
// idle the block takes one transaction per cycle.
// A transaction with is_last set closes the set: in_stall rises and a small
// sequencer drives one shared multiply / divide / root unit through
// n*sumsq, sum^2, n*(n-1), the variance divide, the root, a reciprocal
// multiply for the /255 scale, n*scale and the rounding divide. Each step
// runs its iterations between a start and a result hand-over: multiplies
// take 40 iterations, divides 80, the root 32. When the scale comes out
// zero, n*scale and the rounding divide are skipped; sets of one or no
// samples go straight to the output without using the unit.
// Output channel (out_valid / out_stall) carries scale, zp, status
// from an output register: it holds while out_stall is high, and a new set
// may be accumulated meanwhile; a further result waits for the register.
// Reset (arst_n low) clears the sums, the sequencer and the output valid.
`default_nettype none
module quant_scale_zero_point_calibrator #(
	parameter int MAX_SAMPLES = qszp_pkg::MAX_SAMPLES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic signed [23:0] sample,
	input  wire logic        has_sample,
	input  wire logic        is_last,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [23:0]      scale,
	output logic signed [24:0] zp,
	output logic [1:0]       status
);
	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_CHK   = 11'b00000000010,
		S_MULA  = 11'b00000000100,
		S_MULB  = 11'b00000001000,
		S_MULD  = 11'b00000010000,
		S_DIVV  = 11'b00000100000,
		S_SQRT  = 11'b00001000000,
		S_DIVS  = 11'b00010000000,
		S_MULN  = 11'b00100000000,
		S_DIVQ  = 11'b01000000000,
		S_OUT   = 11'b10000000000
	} state_t;

	state_t state_q;
	logic go_q;
	logic [CNT_W-1:0] cnt_q;
	logic signed [qszp_pkg::SUM_W-1:0] sum_q;
	logic [qszp_pkg::SQ_W-1:0] sq_q;
	logic [qszp_pkg::SUM_W-1:0] mag_q;
	logic neg_q;
	logic [qszp_pkg::ACC_W-1:0] pa_q;
	logic [33:0] den_q;
	logic [31:0] std_q;
	logic [27:0] scl_q;
	logic [45:0] d_q;
	logic [1:0] stat_q;

	logic out_valid_q;
	logic [23:0] scale_q;
	logic signed [24:0] zp_q;
	logic [1:0] status_q;

	logic in_acc;
	logic take;
	logic [23:0] sabs;
	logic [47:0] ssq;
	qszp_pkg::unit_ctl_t ctl;
	logic [qszp_pkg::ACC_W-1:0] opa;
	logic [qszp_pkg::OPB_W-1:0] opb;
	logic u_done;
	logic [qszp_pkg::ACC_W-1:0] u_res;
	logic [35:0] std12;
	logic [43:0] q_ext;
	logic signed [44:0] zp_w;
	logic signed [24:0] zp_sat;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign take = in_acc && has_sample && (cnt_q < CNT_W'(MAX_SAMPLES));
	assign sabs = sample[23] ? 24'(-sample) : 24'(sample);
	assign ssq = sabs * sabs;
	assign std12 = {std_q, 3'b0} + {1'b0, std_q, 2'b0};

	always_comb begin
		ctl.start = go_q;
		ctl.op = qszp_pkg::OP_MUL;
		opa = '0;
		opb = '0;
		case (state_q)
			S_MULA: begin
				opa = qszp_pkg::ACC_W'(cnt_q);
				opb = sq_q;
			end
			S_MULB: begin
				opa = qszp_pkg::ACC_W'(mag_q);
				opb = qszp_pkg::OPB_W'(mag_q);
			end
			S_MULD: begin
				opa = qszp_pkg::ACC_W'(cnt_q);
				opb = qszp_pkg::OPB_W'(cnt_q) - 64'd1;
			end
			S_DIVV: begin
				ctl.op = qszp_pkg::OP_DIV;
				opa = pa_q;
				opb = qszp_pkg::OPB_W'(den_q);
			end
			S_SQRT: begin
				ctl.op = qszp_pkg::OP_SQRT;
				opa = pa_q;
			end
			S_DIVS: begin
				// 12*std / 255 by multiplying with the scaled reciprocal
				opa = qszp_pkg::ACC_W'(std12);
				opb = qszp_pkg::RECIP_255;
			end
			S_MULN: begin
				opa = qszp_pkg::ACC_W'(cnt_q);
				opb = qszp_pkg::OPB_W'(scl_q);
			end
			S_DIVQ: begin
				ctl.op = qszp_pkg::OP_DIV;
				opa = qszp_pkg::ACC_W'({mag_q, 1'b0}) + qszp_pkg::ACC_W'(d_q);
				opb = qszp_pkg::OPB_W'({d_q, 1'b0});
			end
			default: begin
				ctl.op = qszp_pkg::OP_MUL;
			end
		endcase
	end

	qszp_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.opa    (opa),
		.opb    (opb),
		.done   (u_done),
		.res    (u_res)
	);

	// Round to nearest quotient, then apply the sign of the mean and saturate.
	always_comb begin
		q_ext = pa_q[43:0];
		zp_w = neg_q ? 45'(qszp_pkg::ZP_BIAS) + $signed({1'b0, q_ext})
			: 45'(qszp_pkg::ZP_BIAS) - $signed({1'b0, q_ext});
		if (zp_w > 45'(qszp_pkg::ZP_MAX))
			zp_sat = 25'(qszp_pkg::ZP_MAX);
		else if (zp_w < 45'(qszp_pkg::ZP_MIN))
			zp_sat = 25'(qszp_pkg::ZP_MIN);
		else
			zp_sat = zp_w[24:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			go_q <= 1'b0;
			cnt_q <= '0;
			sum_q <= '0;
			sq_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			go_q <= 1'b0;
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (take) begin
						cnt_q <= cnt_q + 1'b1;
						sum_q <= sum_q + qszp_pkg::SUM_W'(sample);
						sq_q <= sq_q + qszp_pkg::SQ_W'(ssq);
					end
					if (in_acc && is_last)
						state_q <= S_CHK;
				end
				S_CHK: begin
					if (cnt_q == '0 || cnt_q == CNT_W'(1)) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_MULA;
						go_q <= 1'b1;
					end
				end
				S_MULA: if (u_done) begin
					state_q <= S_MULB;
					go_q <= 1'b1;
				end
				S_MULB: if (u_done) begin
					state_q <= S_MULD;
					go_q <= 1'b1;
				end
				S_MULD: if (u_done) begin
					state_q <= S_DIVV;
					go_q <= 1'b1;
				end
				S_DIVV: if (u_done) begin
					state_q <= S_SQRT;
					go_q <= 1'b1;
				end
				S_SQRT: if (u_done) begin
					state_q <= S_DIVS;
					go_q <= 1'b1;
				end
				S_DIVS: if (u_done) begin
					if (u_res[qszp_pkg::RECIP_SHIFT +: 28] == '0) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_MULN;
						go_q <= 1'b1;
					end
				end
				S_MULN: if (u_done) begin
					state_q <= S_DIVQ;
					go_q <= 1'b1;
				end
				S_DIVQ: if (u_done)
					state_q <= S_OUT;
				S_OUT: begin
					// hold until the output register is free, then clear the sums
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						cnt_q <= '0;
						sum_q <= '0;
						sq_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_CHK: begin
				mag_q <= sum_q[qszp_pkg::SUM_W-1] ? qszp_pkg::SUM_W'(-sum_q)
					: qszp_pkg::SUM_W'(sum_q);
				neg_q <= sum_q[qszp_pkg::SUM_W-1];
				if (cnt_q == '0)
					stat_q <= qszp_pkg::ST_EMPTY;
				else if (cnt_q == CNT_W'(1))
					stat_q <= qszp_pkg::ST_SINGLE;
				else
					stat_q <= qszp_pkg::ST_OK;
			end
			S_MULA: if (u_done) pa_q <= u_res;
			S_MULB: if (u_done) pa_q <= (pa_q >= u_res) ? pa_q - u_res : '0;
			S_MULD: if (u_done) den_q <= u_res[33:0];
			S_DIVV: if (u_done) pa_q <= qszp_pkg::ACC_W'(u_res[63:0]);
			S_SQRT: if (u_done) std_q <= u_res[31:0];
			S_DIVS: if (u_done) begin
				scl_q <= u_res[qszp_pkg::RECIP_SHIFT +: 28];
				if (u_res[qszp_pkg::RECIP_SHIFT +: 28] == '0) stat_q <= qszp_pkg::ST_ZERO;
			end
			S_MULN: if (u_done) d_q <= u_res[45:0];
			S_DIVQ: if (u_done) pa_q <= u_res;
			S_OUT: if (!out_valid_q) begin
				status_q <= stat_q;
				if (stat_q == qszp_pkg::ST_OK) begin
					scale_q <= scl_q[23:0];
					zp_q <= zp_sat;
				end else begin
					scale_q <= '0;
					zp_q <= '0;
				end
			end
			default: begin
				mag_q <= mag_q;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign scale = scale_q;
	assign zp = zp_q;
	assign status = status_q;
endmodule
`default_nettype wire
